### src/ngps_pkg.sv
// ============================================================================
// ngps_pkg: shared types and constants for the nearest grid point search
// ----------------------------------------------------------------------------
// Command codes, register map, field widths, and the command and status
// bundles that pass between the controller and the datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ngps_pkg;

    // Field widths of the input and result beats.
    localparam int CMD_W   = 2;
    localparam int COORD_W = 32;
    localparam int ROW_W   = 6;
    localparam int COL_W   = 6;
    localparam int TIME_W  = 10;
    localparam int DIST_W  = 63;

    // Configuration register widths.
    localparam int ROWS_W  = 7;
    localparam int COLS_W  = 7;
    localparam int INTV_W  = 16;
    localparam int SAMP_W  = 11;

    // APB port geometry.
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Command codes carried by the cmd field.
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Register indexes (word address paddr[3:2]).
    localparam logic [1:0] REG_ROWS     = 2'd0;
    localparam logic [1:0] REG_COLS     = 2'd1;
    localparam logic [1:0] REG_INTERVAL = 2'd2;
    localparam logic [1:0] REG_SAMPLES  = 2'd3;

    // Register reset values.
    localparam logic [ROWS_W-1:0] ROWS_RESET     = 7'd64;
    localparam logic [COLS_W-1:0] COLS_RESET     = 7'd64;
    localparam logic [INTV_W-1:0] INTERVAL_RESET = 16'd4000;
    localparam logic [SAMP_W-1:0] SAMPLES_RESET  = 11'd1024;

    // Time divider: numerator is 2*t + d, divisor is 2*d.
    localparam int DIV_NUM_W = COORD_W + 1;
    localparam int DIV_DEN_W = INTV_W + 1;
    localparam int DIV_CNT_W = 6;

    // Raw register contents as seen by the datapath.
    typedef struct packed {
        logic [ROWS_W-1:0] rows;
        logic [COLS_W-1:0] cols;
        logic [INTV_W-1:0] interval;
        logic [SAMP_W-1:0] samples;
    } ngps_cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_en;
        logic clear_en;
        logic query_start;
        logic result_load;
    } ngps_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_busy;
        logic div_busy;
        logic out_free;
    } ngps_stat_t;

endpackage

`default_nettype wire

### src/ngps_regs.sv
// ============================================================================
// ngps_regs: APB configuration registers
// ----------------------------------------------------------------------------
// Holds the four configuration registers. Writes complete in the access
// phase; pready is tied high and reads return the stored value.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ngps_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ngps_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ngps_pkg::PDATA_W-1:0]  pwdata,
    output logic      [ngps_pkg::PDATA_W-1:0]  prdata,
    output logic                               pready,
    output ngps_pkg::ngps_cfg_t                cfg
);

    logic [ngps_pkg::ROWS_W-1:0] rows_reg;
    logic [ngps_pkg::COLS_W-1:0] cols_reg;
    logic [ngps_pkg::INTV_W-1:0] interval_reg;
    logic [ngps_pkg::SAMP_W-1:0] samples_reg;
    logic                        wr_en;
    logic [1:0]                  reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];

    // Register file writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg     <= ngps_pkg::ROWS_RESET;
            cols_reg     <= ngps_pkg::COLS_RESET;
            interval_reg <= ngps_pkg::INTERVAL_RESET;
            samples_reg  <= ngps_pkg::SAMPLES_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                ngps_pkg::REG_ROWS:     rows_reg     <= pwdata[ngps_pkg::ROWS_W-1:0];
                ngps_pkg::REG_COLS:     cols_reg     <= pwdata[ngps_pkg::COLS_W-1:0];
                ngps_pkg::REG_INTERVAL: interval_reg <= pwdata[ngps_pkg::INTV_W-1:0];
                ngps_pkg::REG_SAMPLES:  samples_reg  <= pwdata[ngps_pkg::SAMP_W-1:0];
                default:                ;
            endcase
        end
    end

    // Read-back mux.
    always_comb
    begin
        case (reg_sel)
            ngps_pkg::REG_ROWS:     prdata = ngps_pkg::PDATA_W'(rows_reg);
            ngps_pkg::REG_COLS:     prdata = ngps_pkg::PDATA_W'(cols_reg);
            ngps_pkg::REG_INTERVAL: prdata = ngps_pkg::PDATA_W'(interval_reg);
            ngps_pkg::REG_SAMPLES:  prdata = ngps_pkg::PDATA_W'(samples_reg);
            default:                prdata = '0;
        endcase
    end

    assign cfg.rows     = rows_reg;
    assign cfg.cols     = cols_reg;
    assign cfg.interval = interval_reg;
    assign cfg.samples  = samples_reg;

endmodule

`default_nettype wire

### src/ngps_ctrl.sv
// ============================================================================
// ngps_ctrl: command sequencer
// ----------------------------------------------------------------------------
// Accepts input beats, decodes the command, runs a query until the scan and
// the time divider have both finished, then hands the result to the output
// register once it is free.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ngps_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic [ngps_pkg::CMD_W-1:0]   cmd,
    input  ngps_pkg::ngps_stat_t              stat,
    output ngps_pkg::ngps_cmd_t               ctl
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   accept;

    assign in_ready = in_ready_reg;
    assign accept   = in_valid & in_ready_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd)
                        ngps_pkg::CMD_LOAD:  ctl.load_en  = 1'b1;
                        ngps_pkg::CMD_CLEAR: ctl.clear_en = 1'b1;
                        ngps_pkg::CMD_QUERY:
                        begin
                            ctl.query_start = 1'b1;
                            state_next      = ST_SCAN;
                        end
                        default:             ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (!stat.scan_busy && !stat.div_busy)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (stat.out_free)
                begin
                    ctl.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= (state_next == ST_IDLE);
        end
    end

endmodule

`default_nettype wire

### src/ngps_dpath.sv
// ============================================================================
// ngps_dpath: point store, distance pipeline, time divider, result register
// ----------------------------------------------------------------------------
// Holds the coordinate memory and its fill count. A query streams the stored
// points through a distance pipeline and keeps the running best,
// while a restoring divider forms the rounded time index one bit a cycle.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ngps_dpath #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  ngps_pkg::ngps_cfg_t                 cfg,
    input  ngps_pkg::ngps_cmd_t                 ctl,
    output ngps_pkg::ngps_stat_t                stat,
    input  wire logic [ngps_pkg::COORD_W-1:0]   x_coord,
    input  wire logic [ngps_pkg::COORD_W-1:0]   y_coord,
    input  wire logic [ngps_pkg::COORD_W-1:0]   two_way_time,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [ngps_pkg::ROW_W-1:0]     row_index,
    output logic      [ngps_pkg::COL_W-1:0]     col_index,
    output logic      [ngps_pkg::TIME_W-1:0]    time_index,
    output logic      [ngps_pkg::DIST_W-1:0]    distance_squared,
    output logic                                found
);

    localparam int DEPTH     = MAX_ROWS * MAX_COLS;
    localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CW        = ngps_pkg::COORD_W;
    localparam int SQ_W      = 2 * CW;
    localparam int DW        = ngps_pkg::DIST_W;
    localparam int CCNT_W    = ngps_pkg::COLS_W;
    localparam int NW        = ngps_pkg::DIV_NUM_W;
    localparam int DENW      = ngps_pkg::DIV_DEN_W;
    localparam int SW        = ngps_pkg::SAMP_W;
    localparam int ROW_IDX_W = ngps_pkg::ROW_W;
    localparam int GL_W      = ngps_pkg::ROWS_W + ngps_pkg::COLS_W;

    // ------------------------------------------------------------------
    // Effective configuration values.
    // ------------------------------------------------------------------
    logic [ngps_pkg::ROWS_W-1:0]  rows_eff;
    logic [ngps_pkg::COLS_W-1:0]  cols_eff;
    logic [ngps_pkg::INTV_W-1:0]  interval_eff;
    logic [SW-1:0]                samples_eff;
    logic [GL_W-1:0]              grid_limit;

    always_comb
    begin
        if (cfg.rows == '0)
            rows_eff = ngps_pkg::ROWS_W'(1);
        else if (32'(cfg.rows) > MAX_ROWS)
            rows_eff = ngps_pkg::ROWS_W'(MAX_ROWS);
        else
            rows_eff = cfg.rows;

        if (cfg.cols == '0)
            cols_eff = ngps_pkg::COLS_W'(1);
        else if (32'(cfg.cols) > MAX_COLS)
            cols_eff = ngps_pkg::COLS_W'(MAX_COLS);
        else
            cols_eff = cfg.cols;

        if (cfg.samples == '0)
            samples_eff = SW'(1);
        else if (32'(cfg.samples) > MAX_SAMPLES)
            samples_eff = SW'(MAX_SAMPLES);
        else
            samples_eff = cfg.samples;

        interval_eff = (cfg.interval == '0) ? ngps_pkg::INTV_W'(1) : cfg.interval;
    end

    assign grid_limit = GL_W'(rows_eff) * GL_W'(cols_eff);

    // ------------------------------------------------------------------
    // Fill count and load acceptance.
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] points_loaded_reg;
    logic             load_ok;

    assign load_ok = ctl.load_en
                   && (32'(points_loaded_reg) < 32'(grid_limit))
                   && (32'(points_loaded_reg) < DEPTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            points_loaded_reg <= '0;
        else if (ctl.clear_en)
            points_loaded_reg <= '0;
        else if (load_ok)
            points_loaded_reg <= points_loaded_reg + CNT_W'(1);
    end

    // ------------------------------------------------------------------
    // Scan sequencing: address, grid position of the entry being read.
    // ------------------------------------------------------------------
    logic [AW-1:0]     scan_addr_reg;
    logic [ROW_IDX_W-1:0] scan_row_reg;
    logic [CCNT_W-1:0] scan_col_reg;
    logic              issue_reg;
    logic              scan_last;

    assign scan_last = (32'(scan_addr_reg) + 32'd1 == 32'(points_loaded_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
        end
        else if (ctl.query_start)
        begin
            issue_reg <= (points_loaded_reg != '0);
        end
        else if (issue_reg && scan_last)
        begin
            issue_reg <= 1'b0;
        end
    end

    // The row counter wraps at 64, which is the six-bit row the result reports.
    always_ff @(posedge clk)
    begin
        if (ctl.query_start)
        begin
            scan_addr_reg <= '0;
            scan_row_reg  <= '0;
            scan_col_reg  <= '0;
        end
        else if (issue_reg)
        begin
            scan_addr_reg <= scan_addr_reg + AW'(1);
            if (scan_col_reg + CCNT_W'(1) >= cols_eff)
            begin
                scan_col_reg <= '0;
                scan_row_reg <= scan_row_reg + ROW_IDX_W'(1);
            end
            else
            begin
                scan_col_reg <= scan_col_reg + CCNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Coordinate memory: {x, y} per entry, one write and one read port.
    // ------------------------------------------------------------------
    logic [2*CW-1:0] store_reg [DEPTH];
    logic [2*CW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            store_reg[points_loaded_reg[AW-1:0]] <= {x_coord, y_coord};
        end
        if (issue_reg)
        begin
            rd_data_reg <= store_reg[scan_addr_reg];
        end
    end

    // ------------------------------------------------------------------
    // Query point capture.
    // ------------------------------------------------------------------
    logic [CW-1:0] qx_reg;
    logic [CW-1:0] qy_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.query_start)
        begin
            qx_reg <= x_coord;
            qy_reg <= y_coord;
        end
    end

    // ------------------------------------------------------------------
    // Distance pipeline. Stage 1 is the memory read.
    // ------------------------------------------------------------------
    logic                 s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    logic [ROW_IDX_W-1:0] s1_row_reg, s2_row_reg, s3_row_reg, s4_row_reg;
    logic [CCNT_W-1:0]    s1_col_reg, s2_col_reg, s3_col_reg, s4_col_reg;
    logic [CW-1:0]        s2_adx_reg, s2_ady_reg;
    logic [SQ_W-1:0]      s3_sqx_reg, s3_sqy_reg;
    logic [DW-1:0]        s4_dist_reg;

    logic [CW:0]          dx, dy, adx, ady;
    logic [SQ_W:0]        sq_sum;
    logic [DW-1:0]        dist_sat;

    // Differences are 33 bits; their magnitude always fits in 32.
    always_comb
    begin
        dx     = {qx_reg[CW-1], qx_reg} - {rd_data_reg[2*CW-1], rd_data_reg[2*CW-1:CW]};
        dy     = {qy_reg[CW-1], qy_reg} - {rd_data_reg[CW-1], rd_data_reg[CW-1:0]};
        adx    = dx[CW] ? (~dx + (CW+1)'(1)) : dx;
        ady    = dy[CW] ? (~dy + (CW+1)'(1)) : dy;
        sq_sum = {1'b0, s3_sqx_reg} + {1'b0, s3_sqy_reg};
        // Saturate on carry out or any value past the 63-bit range.
        if (sq_sum[SQ_W] || sq_sum[SQ_W-1])
            dist_sat = '1;
        else
            dist_sat = sq_sum[DW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= issue_reg;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_row_reg  <= scan_row_reg;
        s1_col_reg  <= scan_col_reg;
        s2_row_reg  <= s1_row_reg;
        s2_col_reg  <= s1_col_reg;
        s2_adx_reg  <= adx[CW-1:0];
        s2_ady_reg  <= ady[CW-1:0];
        s3_row_reg  <= s2_row_reg;
        s3_col_reg  <= s2_col_reg;
        s3_sqx_reg  <= SQ_W'(s2_adx_reg) * SQ_W'(s2_adx_reg);
        s3_sqy_reg  <= SQ_W'(s2_ady_reg) * SQ_W'(s2_ady_reg);
        s4_row_reg  <= s3_row_reg;
        s4_col_reg  <= s3_col_reg;
        s4_dist_reg <= dist_sat;
    end

    // ------------------------------------------------------------------
    // Running best: strict less-than keeps the earliest point on a tie.
    // ------------------------------------------------------------------
    logic                 best_any_reg;
    logic [DW-1:0]        best_dist_reg;
    logic [ROW_IDX_W-1:0] best_row_reg;
    logic [CCNT_W-1:0]    best_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            best_any_reg <= 1'b0;
        else if (ctl.query_start)
            best_any_reg <= 1'b0;
        else if (s4_valid_reg)
            best_any_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (s4_valid_reg && (!best_any_reg || s4_dist_reg < best_dist_reg))
        begin
            best_dist_reg <= s4_dist_reg;
            best_row_reg  <= s4_row_reg;
            best_col_reg  <= s4_col_reg;
        end
    end

    // ------------------------------------------------------------------
    // Time index divider: (2t + d) / (2d), restoring, one bit a cycle.
    // A time at or below zero loads a zero numerator.
    // ------------------------------------------------------------------
    logic [NW-1:0]                  div_num_reg;
    logic [DENW-1:0]                div_den_reg;
    logic [DENW-1:0]                div_rem_reg;
    logic [ngps_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic                           div_busy_reg;
    logic [DENW:0]                  rem_shift;
    logic                           rem_ge;
    logic                           time_pos;

    assign time_pos  = !two_way_time[CW-1] && (two_way_time != '0);
    assign rem_shift = {div_rem_reg, div_num_reg[NW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, div_den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_busy_reg <= 1'b0;
        else if (ctl.query_start)
            div_busy_reg <= 1'b1;
        else if (div_busy_reg && div_cnt_reg == ngps_pkg::DIV_CNT_W'(NW - 1))
            div_busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.query_start)
        begin
            div_num_reg <= time_pos
                         ? ({two_way_time, 1'b0} + NW'(interval_eff))
                         : '0;
            div_den_reg <= {interval_eff, 1'b0};
            div_rem_reg <= '0;
            div_cnt_reg <= '0;
        end
        else if (div_busy_reg)
        begin
            div_num_reg <= {div_num_reg[NW-2:0], rem_ge};
            div_rem_reg <= rem_ge ? DENW'(rem_shift - {1'b0, div_den_reg})
                                  : rem_shift[DENW-1:0];
            div_cnt_reg <= div_cnt_reg + ngps_pkg::DIV_CNT_W'(1);
        end
    end

    // Clamp the quotient to the last sample.
    logic [SW-1:0] last_sample;
    logic [SW-1:0] time_clamped;

    assign last_sample  = samples_eff - SW'(1);
    assign time_clamped = (div_num_reg > NW'(last_sample)) ? last_sample
                                                           : div_num_reg[SW-1:0];

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    logic                          out_valid_reg;
    logic [ngps_pkg::ROW_W-1:0]    out_row_reg;
    logic [ngps_pkg::COL_W-1:0]    out_col_reg;
    logic [ngps_pkg::TIME_W-1:0]   out_time_reg;
    logic [DW-1:0]                 out_dist_reg;
    logic                          out_found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (ctl.result_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.result_load)
        begin
            out_found_reg <= best_any_reg;
            out_row_reg   <= best_any_reg ? best_row_reg : '0;
            out_col_reg   <= best_any_reg ? best_col_reg[ngps_pkg::COL_W-1:0] : '0;
            out_dist_reg  <= best_any_reg ? best_dist_reg : '0;
            out_time_reg  <= time_clamped[ngps_pkg::TIME_W-1:0];
        end
    end

    assign out_valid        = out_valid_reg;
    assign row_index        = out_row_reg;
    assign col_index        = out_col_reg;
    assign time_index       = out_time_reg;
    assign distance_squared = out_dist_reg;
    assign found            = out_found_reg;

    // ------------------------------------------------------------------
    // Status to the controller.
    // ------------------------------------------------------------------
    assign stat.scan_busy = issue_reg | s1_valid_reg | s2_valid_reg
                          | s3_valid_reg | s4_valid_reg;
    assign stat.div_busy  = div_busy_reg;
    assign stat.out_free  = !out_valid_reg || out_ready;

endmodule

`default_nettype wire

### src/nearest_grid_point_search.sv
// ============================================================================
// nearest_grid_point_search: brute-force nearest stored grid point
// ----------------------------------------------------------------------------
// Top level: APB registers, command sequencer and datapath.
// ============================================================================
// Load beats (cmd 0) store one point each, row by row; loads past
// rows_in_use * cols_in_use are dropped. A clear (cmd 0x2) empties the
// table with no clearing pass, since a fill count tracks which entries
// hold data. A query (cmd 1) reads every stored point through the single
// memory read port, one per cycle, into a distance pipeline, while a
// restoring divider forms the time index one bit per cycle in parallel.
// Results sit in an output register; the next beat is taken once the
// query result has moved there.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nearest_grid_point_search #(
    parameter int MAX_ROWS    = 64,
    parameter int MAX_COLS    = 64,
    parameter int MAX_SAMPLES = 1024
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // Configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ngps_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [ngps_pkg::PDATA_W-1:0]   pwdata,
    output logic      [ngps_pkg::PDATA_W-1:0]   prdata,
    output logic                                pready,
    // Input channel
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [ngps_pkg::CMD_W-1:0]     cmd,
    input  wire logic [ngps_pkg::COORD_W-1:0]   x_coord,
    input  wire logic [ngps_pkg::COORD_W-1:0]   y_coord,
    input  wire logic [ngps_pkg::COORD_W-1:0]   two_way_time,
    // Result channel
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic      [ngps_pkg::ROW_W-1:0]     row_index,
    output logic      [ngps_pkg::COL_W-1:0]     col_index,
    output logic      [ngps_pkg::TIME_W-1:0]    time_index,
    output logic      [ngps_pkg::DIST_W-1:0]    distance_squared,
    output logic                                found
);

    ngps_pkg::ngps_cfg_t  cfg;
    ngps_pkg::ngps_cmd_t  ctl;
    ngps_pkg::ngps_stat_t stat;

    ngps_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ngps_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .stat     (stat),
        .ctl      (ctl)
    );

    ngps_dpath #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_dpath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg              (cfg),
        .ctl              (ctl),
        .stat             (stat),
        .x_coord          (x_coord),
        .y_coord          (y_coord),
        .two_way_time     (two_way_time),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .row_index        (row_index),
        .col_index        (col_index),
        .time_index       (time_index),
        .distance_squared (distance_squared),
        .found            (found)
    );

endmodule

`default_nettype wire

### src/ngps_checker.sv
// ============================================================================
// ngps_checker: port-level checks for the nearest grid point search
// ----------------------------------------------------------------------------
// Watches the top-level ports and flags result beats that break the block's
// sequencing rules. Attached to the top level by the bind at the end.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ngps_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_valid,
    input wire logic                           in_ready,
    input wire logic [ngps_pkg::CMD_W-1:0]     cmd,
    input wire logic                           out_valid,
    input wire logic                           out_ready,
    input wire logic [ngps_pkg::ROW_W-1:0]     row_index,
    input wire logic [ngps_pkg::COL_W-1:0]     col_index,
    input wire logic [ngps_pkg::TIME_W-1:0]    time_index,
    input wire logic [ngps_pkg::DIST_W-1:0]    distance_squared,
    input wire logic                           found
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(row_index)
            && $stable(col_index) && $stable(time_index)
            && $stable(distance_squared) && $stable(found))
        else $error("result beat changed while stalled");

    // An empty table reports the origin and a zero distance.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !found |-> row_index == '0 && col_index == '0
            && distance_squared == '0)
        else $error("empty-table result carries nonzero fields");

    // A query closes the input side once it is accepted.
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd == ngps_pkg::CMD_QUERY |=> !in_ready)
        else $error("input accepted during a query");

    // Loads, clears and unused codes never raise a result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && cmd != ngps_pkg::CMD_QUERY && !out_valid
            |=> !out_valid)
        else $error("result beat without a query");

endmodule

bind nearest_grid_point_search ngps_checker u_ngps_checker (.*);

`default_nettype wire
